@@ hw/rtl/pesh_pkg.sv @@
// Shared types, constants and helpers of the PES header parser.
`default_nettype none

package pesh_pkg;

  // Width of the per-packet byte counter and of the payload length.
  localparam int unsigned PosW = 16;

  // Fixed byte positions inside the PES header.
  localparam logic [PosW-1:0] PosStartCodeEnd = 16'd3;
  localparam logic [PosW-1:0] PosStreamId     = 16'd3;
  localparam logic [PosW-1:0] PosFlags        = 16'd7;
  localparam logic [PosW-1:0] PosHeaderLen    = 16'd8;
  localparam logic [PosW-1:0] PosPts0         = 16'd9;
  localparam logic [PosW-1:0] PosPts1         = 16'd10;
  localparam logic [PosW-1:0] PosPts2         = 16'd11;
  localparam logic [PosW-1:0] PosPts3         = 16'd12;
  localparam logic [PosW-1:0] PosPts4         = 16'd13;
  localparam logic [PosW-1:0] MinHeaderBytes  = 16'd9;
  localparam logic [PosW-1:0] MinPtsBytes     = 16'd14;
  localparam logic [8:0]      FixedHeaderLen  = 9'd9;

  // Stream id ranges.
  localparam logic [7:0] SidPrivate1 = 8'hBD;
  localparam logic [7:0] SidAudioLo  = 8'hC0;
  localparam logic [7:0] SidAudioHi  = 8'hDF;
  localparam logic [7:0] SidVideoLo  = 8'hE0;
  localparam logic [7:0] SidVideoHi  = 8'hEF;

  // Sequence header and aspect ratio codes.
  localparam logic [7:0] SeqHeaderCode = 8'hB3;
  localparam logic [3:0] AspectCode4x3  = 4'h2;
  localparam logic [3:0] AspectCode16x9 = 4'h3;

  // Progress through a video sequence header in the payload.
  localparam logic [2:0] VidStartMatched = 3'd4;
  localparam logic [2:0] VidSizeDone     = 3'd5;
  localparam logic [2:0] VidRelStage0    = 3'd4;
  localparam logic [2:0] VidRelStage1    = 3'd5;
  localparam logic [2:0] VidRelStage2    = 3'd6;
  localparam logic [2:0] VidRelAspect    = 3'd7;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_START  = 2'd1,
    ST_BAD_ID    = 2'd2,
    ST_TRUNCATED = 2'd3
  } pesh_status_e;

  typedef enum logic [1:0] {
    KIND_PRIVATE = 2'd0,
    KIND_AUDIO   = 2'd1,
    KIND_VIDEO   = 2'd2
  } pesh_kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_packet;
  } pesh_in_t;

  typedef struct packed {
    pesh_status_e status;
    pesh_kind_e   stream_kind;
    logic [31:0]  pts_value;
    logic [8:0]   payload_offset;
    logic [15:0]  payload_length;
    logic [11:0]  picture_width;
    logic [11:0]  picture_height;
    logic         aspect_wide;
  } pesh_out_t;

  // A byte tagged by the front end with its place in the packet.
  typedef struct packed {
    logic [7:0]      data_byte;
    logic            end_of_packet;
    logic [PosW-1:0] pos;
    logic            in_window;
  } pesh_tag_t;

  // Byte expected at a given offset of the sequence header start code.
  function automatic logic [7:0] pesh_seq_byte(input logic [1:0] idx);
    logic [7:0] val;
    case (idx)
      2'd0: val = 8'h00;
      2'd1: val = 8'h00;
      2'd2: val = 8'h01;
      2'd3: val = SeqHeaderCode;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/pes_header_parser.sv @@
// After a packet's final byte leaves the queue, its result is held in the output register.
// Throughput: one packet byte per cycle while the queue is not full; the back end retires one
// queued byte per cycle, except that the final byte of a packet waits for a free output
// register; other bytes keep flowing while a finished result is still stalled at the output.
// Reset: asynchronous, active low; it clears the byte counter, the queue, the parse state,
// the kept PTS, picture size and aspect (4:3) and the output valid.
`default_nettype none

module pes_header_parser import pesh_pkg::*; #(
  // Bytes of a packet beyond this count are ignored and the length saturates.
  parameter int unsigned MAX_PACKET_BYTES = 65535,
  // Entries of the queue between front and back end; a power of two, at least 2.
  parameter int unsigned QUEUE_DEPTH      = 4
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire pesh_in_t in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output pesh_out_t     out_data_o
);

  // The front end stamps every incoming transaction with its byte position in the
  // packet, the queue decouples it from the back end, and the back end walks the
  // header fields and emits one result transaction per packet.
  logic      q_push, q_full, q_pop, q_valid;
  pesh_tag_t q_in, q_head;

  pesh_front #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_in)
  );

  pesh_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  // The back end holds the per-packet parse state and the output register.
  pesh_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

@@ hw/rtl/pesh_front.sv @@
// Front end: accepts packet bytes and tags each with its byte position.
`default_nettype none

module pesh_front import pesh_pkg::*; #(
  parameter int unsigned MAX_PACKET_BYTES = 65535
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire pesh_in_t  in_data_i,
  input  wire logic      q_full_i,
  output logic           q_push_o,
  output pesh_tag_t      q_data_o
);

  localparam logic [PosW-1:0] MaxPos = PosW'(MAX_PACKET_BYTES);

  logic [PosW-1:0] pos_q, pos_d;
  logic            in_window;

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i & ~q_full_i;
  // Bytes past the size limit are dropped by the back end.
  assign in_window  = (pos_q < MaxPos);

  assign q_data_o.data_byte     = in_data_i.data_byte;
  assign q_data_o.end_of_packet = in_data_i.end_of_packet;
  assign q_data_o.pos           = pos_q;
  assign q_data_o.in_window     = in_window;

  always_comb begin
    pos_d = pos_q;
    if (q_push_o) begin
      if (in_data_i.end_of_packet) begin
        pos_d = '0;
      end else if (in_window) begin
        pos_d = pos_q + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/pesh_queue.sv @@
// Small FIFO of tagged bytes between the front end and the back end.
`default_nettype none

module pesh_queue import pesh_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire pesh_tag_t push_data_i,
  output logic           full_o,
  input  wire logic      pop_i,
  output logic           valid_o,
  output pesh_tag_t      head_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  pesh_tag_t       mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/pesh_back.sv @@
// Back end: updates the parse state per byte and builds the packet result.
`default_nettype none

module pesh_back import pesh_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      q_valid_i,
  input  wire pesh_tag_t q_head_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output pesh_out_t      out_data_o
);

  pesh_kind_e   kind_q, kind_d;
  pesh_status_e err_q, err_d;
  logic [7:0]   hlen_q, hlen_d;
  logic         pts_flag_q, pts_flag_d;
  logic [32:0]  gather_q, gather_d;
  logic [31:0]  pts_kept_q, pts_kept_d;
  logic [2:0]   vmatch_q, vmatch_d;
  logic [23:0]  vstage_q, vstage_d;
  logic [11:0]  width_q, width_d;
  logic [11:0]  height_q, height_d;
  logic         aspect_q, aspect_d;
  logic         out_valid_q, out_valid_d;
  pesh_out_t    out_q, res;

  logic [PosW-1:0] p, rel, len;
  logic [7:0]      b;
  logic [8:0]      start_cur, start_nxt;
  logic            take, last_pop;
  pesh_status_e    status;

  assign p    = q_head_i.pos;
  assign b    = q_head_i.data_byte;
  assign take = q_valid_i & q_head_i.in_window;

  // Non-final bytes never wait on the output; the final one needs a free slot.
  assign q_pop_o  = q_valid_i & (~q_head_i.end_of_packet | ~out_valid_q | ~out_stall_i);
  assign last_pop = q_pop_o & q_head_i.end_of_packet;

  assign start_cur = FixedHeaderLen + {1'b0, hlen_q};
  assign rel       = p - {7'd0, start_cur};

  always_comb begin
    kind_d     = kind_q;
    err_d      = err_q;
    hlen_d     = hlen_q;
    pts_flag_d = pts_flag_q;
    gather_d   = gather_q;
    vmatch_d   = vmatch_q;
    vstage_d   = vstage_q;
    width_d    = width_q;
    height_d   = height_q;
    aspect_d   = aspect_q;
    if (take) begin
      if (p < PosStartCodeEnd) begin
        if ((b != ((p == 16'd2) ? 8'h01 : 8'h00)) && (err_q == ST_OK)) begin
          err_d = ST_NO_START;
        end
      end else if (err_q == ST_OK) begin
        if (p == PosStreamId) begin
          if (b == SidPrivate1) begin
            kind_d = KIND_PRIVATE;
          end else if (b >= SidAudioLo && b <= SidAudioHi) begin
            kind_d = KIND_AUDIO;
          end else if (b >= SidVideoLo && b <= SidVideoHi) begin
            kind_d = KIND_VIDEO;
          end else begin
            err_d = ST_BAD_ID;
          end
        end else begin
          if (p == PosFlags) begin
            pts_flag_d = b[7];
          end
          if (p == PosHeaderLen) begin
            hlen_d = b;
          end
          if (p == PosPts0) gather_d[32:30] = gather_q[32:30] | b[3:1];
          if (p == PosPts1) gather_d[29:22] = gather_q[29:22] | b;
          if (p == PosPts2) gather_d[21:15] = gather_q[21:15] | b[7:1];
          if (p == PosPts3) gather_d[14:7]  = gather_q[14:7]  | b;
          if (p == PosPts4) gather_d[6:0]   = gather_q[6:0]   | b[7:1];
          if (kind_q == KIND_VIDEO && p >= PosPts0 && p >= {7'd0, start_cur}) begin
            if (rel < 16'd4) begin
              if ({13'd0, vmatch_q} == rel && b == pesh_seq_byte(rel[1:0])) begin
                vmatch_d = rel[2:0] + 3'd1;
              end
            end else if (vmatch_q == VidStartMatched) begin
              if (rel == {13'd0, VidRelStage0}) begin
                vstage_d[23:16] = vstage_q[23:16] | b;
              end else if (rel == {13'd0, VidRelStage1}) begin
                vstage_d[15:8] = vstage_q[15:8] | b;
              end else if (rel == {13'd0, VidRelStage2}) begin
                vstage_d[7:0] = vstage_q[7:0] | b;
              end else if (rel == {13'd0, VidRelAspect}) begin
                width_d  = {vstage_q[23:16], vstage_q[15:12]};
                height_d = {vstage_q[11:8], vstage_q[7:0]};
                if (b[7:4] == AspectCode4x3) begin
                  aspect_d = 1'b0;
                end else if (b[7:4] == AspectCode16x9) begin
                  aspect_d = 1'b1;
                end
                vmatch_d = VidSizeDone;
              end
            end
          end
        end
      end
    end
  end

  // Result of the packet, from the state after its final byte.
  assign start_nxt = FixedHeaderLen + {1'b0, hlen_d};
  assign len       = take ? p + PosW'(1) : p;

  always_comb begin
    status                = err_d;
    pts_kept_d            = pts_kept_q;
    res.payload_offset    = '0;
    res.payload_length    = '0;
    if (err_d == ST_OK) begin
      if (len < MinHeaderBytes) begin
        status = ST_TRUNCATED;
      end else begin
        res.payload_offset = start_nxt;
        if ((pts_flag_d && len < MinPtsBytes) || len < {7'd0, start_nxt} ||
            (kind_d == KIND_VIDEO && vmatch_d == VidStartMatched)) begin
          status = ST_TRUNCATED;
        end
      end
      if (status == ST_OK) begin
        res.payload_length = len - {7'd0, start_nxt};
        if (pts_flag_d) begin
          pts_kept_d = gather_d[32:1];
        end
      end
    end
    res.status         = status;
    res.stream_kind    = (status == ST_NO_START || status == ST_BAD_ID) ? KIND_PRIVATE
                                                                         : kind_d;
    res.pts_value      = pts_kept_d;
    res.picture_width  = width_d;
    res.picture_height = height_d;
    res.aspect_wide    = aspect_d;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (last_pop) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (last_pop) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q      <= KIND_PRIVATE;
      err_q       <= ST_OK;
      hlen_q      <= '0;
      pts_flag_q  <= 1'b0;
      gather_q    <= '0;
      vmatch_q    <= '0;
      vstage_q    <= '0;
      pts_kept_q  <= '0;
      width_q     <= '0;
      height_q    <= '0;
      aspect_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      width_q     <= width_d;
      height_q    <= height_d;
      aspect_q    <= aspect_d;
      if (last_pop) begin
        pts_kept_q <= pts_kept_d;
        kind_q     <= KIND_PRIVATE;
        err_q      <= ST_OK;
        hlen_q     <= '0;
        pts_flag_q <= 1'b0;
        gather_q   <= '0;
        vmatch_q   <= '0;
        vstage_q   <= '0;
      end else if (q_pop_o) begin
        kind_q     <= kind_d;
        err_q      <= err_d;
        hlen_q     <= hlen_d;
        pts_flag_q <= pts_flag_d;
        gather_q   <= gather_d;
        vmatch_q   <= vmatch_d;
        vstage_q   <= vstage_d;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

@@ tb/sv/pesh_result_checker.sv @@
// Watches both channels of the PES header parser, predicts each packet report and compares it.
module pesh_result_checker import pesh_pkg::*; #(
  parameter int unsigned MAX_PACKET_BYTES = 65535
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  pesh_in_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  pesh_out_t out_data_i,
  output int        fail_count_o,
  output int        pending_o
);

  pesh_out_t    awaited_reports[$];

  // Per-packet parse state.
  int unsigned  byte_pos;
  pesh_kind_e   kind;
  pesh_status_e fault;
  logic [7:0]   hdr_len;
  logic         pts_present;
  logic [32:0]  pts_acc;
  logic [2:0]   seq_match;
  logic [23:0]  seq_stage;

  // State kept across packets.
  logic [31:0]  pts_last;
  logic [11:0]  pic_w;
  logic [11:0]  pic_h;
  logic         wide;

  task automatic clear_packet();
    byte_pos    = 0;
    kind        = KIND_PRIVATE;
    fault       = ST_OK;
    hdr_len     = '0;
    pts_present = 1'b0;
    pts_acc     = '0;
    seq_match   = '0;
    seq_stage   = '0;
  endtask

  // Tracks a sequence header at the head of a video payload; rel counts payload bytes.
  task automatic scan_seq_header(input int unsigned rel, input logic [7:0] b);
    logic [7:0] code;
    if (rel < 4) begin
      code = (rel == 3) ? SeqHeaderCode : (rel == 2) ? 8'h01 : 8'h00;
      if (seq_match == 3'(rel) && b == code) seq_match = 3'(rel + 1);
    end else if (seq_match == VidStartMatched) begin
      if (rel < 7) begin
        seq_stage = seq_stage | (24'(b) << (8 * (6 - rel)));
      end else if (rel == 7) begin
        pic_w = {seq_stage[23:16], seq_stage[15:12]};
        pic_h = {seq_stage[11:8], seq_stage[7:0]};
        if (b[7:4] == AspectCode4x3) wide = 1'b0;
        else if (b[7:4] == AspectCode16x9) wide = 1'b1;
        seq_match = VidSizeDone;
      end
    end
  endtask

  task automatic parse_byte(input int unsigned p, input logic [7:0] b);
    int unsigned start;
    if (p < PosStartCodeEnd) begin
      if (b != ((p == 2) ? 8'h01 : 8'h00) && fault == ST_OK) fault = ST_NO_START;
      return;
    end
    if (fault != ST_OK) return;
    if (p == PosStreamId) begin
      if (b == SidPrivate1) kind = KIND_PRIVATE;
      else if (b >= SidAudioLo && b <= SidAudioHi) kind = KIND_AUDIO;
      else if (b >= SidVideoLo && b <= SidVideoHi) kind = KIND_VIDEO;
      else fault = ST_BAD_ID;
      return;
    end
    if (p == PosFlags) pts_present = b[7];
    if (p == PosHeaderLen) hdr_len = b;
    case (p)
      PosPts0: pts_acc[32:30] = b[3:1];
      PosPts1: pts_acc[29:22] = b;
      PosPts2: pts_acc[21:15] = b[7:1];
      PosPts3: pts_acc[14:7]  = b;
      PosPts4: pts_acc[6:0]   = b[7:1];
      default: ;
    endcase
    start = FixedHeaderLen + hdr_len;
    if (kind == KIND_VIDEO && p >= PosPts0 && p >= start) scan_seq_header(p - start, b);
  endtask

  // Consumes one accepted byte; the final byte of a packet queues its report.
  task automatic account_byte(input pesh_in_t item);
    int unsigned len;
    int unsigned start;
    pesh_out_t   rep;
    if (byte_pos < MAX_PACKET_BYTES) begin
      parse_byte(byte_pos, item.data_byte);
      byte_pos++;
    end
    if (!item.end_of_packet) return;
    rep        = '0;
    len        = byte_pos;
    start      = FixedHeaderLen + hdr_len;
    rep.status = fault;
    if (fault == ST_OK) begin
      if (len < MinHeaderBytes) begin
        rep.status = ST_TRUNCATED;
      end else begin
        rep.payload_offset = 9'(start);
        if ((pts_present && len < MinPtsBytes) || len < start ||
            (kind == KIND_VIDEO && seq_match == VidStartMatched)) rep.status = ST_TRUNCATED;
      end
      if (rep.status == ST_OK) begin
        rep.payload_length = 16'(len - start);
        if (pts_present) pts_last = pts_acc[32:1];
      end
    end
    rep.stream_kind    = (rep.status == ST_NO_START || rep.status == ST_BAD_ID) ?
                         KIND_PRIVATE : kind;
    rep.pts_value      = pts_last;
    rep.picture_width  = pic_w;
    rep.picture_height = pic_h;
    rep.aspect_wide    = wide;
    awaited_reports.push_back(rep);
    clear_packet();
  endtask

  function automatic int field_differs(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    pesh_out_t want;
    pesh_out_t got;
    if (!rst_ni) begin
      clear_packet();
      pts_last = '0;
      pic_w    = '0;
      pic_h    = '0;
      wide     = 1'b0;
      awaited_reports.delete();
      fail_count_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) account_byte(in_data_i);
      if (out_valid_i && !out_stall_i) begin
        got = out_data_i;
        if (awaited_reports.size() == 0) begin
          $error("unexpected report transaction: 0x%0h", got);
          fail_count_o++;
        end else begin
          want = awaited_reports.pop_front();
          fail_count_o += field_differs("status", want.status, got.status)
                        + field_differs("stream_kind", want.stream_kind, got.stream_kind)
                        + field_differs("pts_value", want.pts_value, got.pts_value)
                        + field_differs("payload_offset", want.payload_offset,
                                        got.payload_offset)
                        + field_differs("payload_length", want.payload_length,
                                        got.payload_length)
                        + field_differs("picture_width", want.picture_width,
                                        got.picture_width)
                        + field_differs("picture_height", want.picture_height,
                                        got.picture_height)
                        + field_differs("aspect_wide", want.aspect_wide, got.aspect_wide);
        end
      end
    end
    pending_o = awaited_reports.size();
  end

endmodule

@@ tb/sv/pes_header_parser_tb.sv @@
// Testbench top of the PES header parser: packet stimulus, receiver stalls and the verdict.
module pes_header_parser_tb;
  import pesh_pkg::*;

  localparam int unsigned MaxPacketBytes = 65535;
  // The slowest correct run stays well under the cycle limit: about 900 bytes with the widest
  // gaps that draw_gap gives, plus the long hold-off.
  localparam int unsigned CycleLimit     = 200_000;
  localparam int unsigned DrainLimit     = 5000;
  // Cycles waited after draining, to catch any extra result before the verdict.
  localparam int unsigned SettleCycles   = 20;
  localparam int unsigned LongHoldCycles = 300;
  localparam int unsigned TotalBytes     = 900;
  localparam int unsigned RandomPackets  = 8;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  pesh_in_t  in_data;
  logic      out_valid;
  logic      out_stall;
  pesh_out_t out_data;

  int          fail_count;
  int          pending_reports;
  logic [7:0]  pkt_bytes[$];
  int unsigned bytes_sent;
  int unsigned packets_sent;
  // Raised by the stimulus to ask the receiver for one long hold-off.
  bit          long_hold;

  pes_header_parser #(
    .MAX_PACKET_BYTES(MaxPacketBytes)
  ) DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  pesh_result_checker #(
    .MAX_PACKET_BYTES(MaxPacketBytes)
  ) checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending_reports)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Idle cycles before a transaction. Mode 0 gives back-to-back stretches, mode 1 the
  // widest random gaps, and mode 2 short hiccups only.
  function automatic int unsigned draw_gap(input int unsigned mode);
    case (mode)
      0:       return 0;
      1:       return $urandom_range(0, 18);
      default: return $urandom_range(0, 2);
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the byte was taken.
  // Valid stays high across back-to-back bytes so it is never dropped and raised in
  // the same time step.
  task automatic send_byte(input logic [7:0] b, input logic last, input int unsigned gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, end_of_packet: last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_packet(input int unsigned mode);
    foreach (pkt_bytes[i]) send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1, draw_gap(mode));
    bytes_sent   += pkt_bytes.size();
    packets_sent++;
  endtask

  task automatic push_random(input int unsigned n);
    repeat (n) pkt_bytes.push_back(8'($urandom));
  endtask

  // Start code, stream id, random length and flag bytes, then hlen random header bytes,
  // which is where the PTS lives when the flag is set.
  task automatic start_header(input logic [7:0] sid, input logic pts_on,
                              input logic [7:0] hlen);
    pkt_bytes = {8'h00, 8'h00, 8'h01, sid, 8'($urandom), 8'($urandom), 8'($urandom),
                 {pts_on, 7'($urandom)}, hlen};
    push_random(hlen);
  endtask

  task automatic push_seq_header(input logic [11:0] w, input logic [11:0] h,
                                 input logic [7:0] aspect);
    pkt_bytes.push_back(8'h00);
    pkt_bytes.push_back(8'h00);
    pkt_bytes.push_back(8'h01);
    pkt_bytes.push_back(SeqHeaderCode);
    pkt_bytes.push_back(w[11:4]);
    pkt_bytes.push_back({w[3:0], h[11:8]});
    pkt_bytes.push_back(h[7:0]);
    pkt_bytes.push_back(aspect);
  endtask

  // Mostly well-formed packets with random content. A quarter are broken: a damaged
  // start code, an arbitrary stream id, or a cut at a random length.
  task automatic random_packet();
    int unsigned pick;
    int unsigned hlen;
    int unsigned cut;
    logic [7:0]  sid;
    logic [7:0]  aspect;
    pick = $urandom_range(0, 2);
    sid  = (pick == 0) ? SidPrivate1 :
           (pick == 1) ? 8'($urandom_range(SidAudioLo, SidAudioHi)) :
                         8'($urandom_range(SidVideoLo, SidVideoHi));
    // Now and then a long header pushes the payload offset toward its maximum.
    hlen = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12);
    start_header(sid, 1'($urandom), 8'(hlen));
    if (sid >= SidVideoLo) begin
      aspect = ($urandom_range(0, 3) == 0) ? 8'($urandom) :
               {($urandom_range(0, 1) != 0) ? AspectCode16x9 : AspectCode4x3, 4'($urandom)};
      case ($urandom_range(0, 3))
        0, 1: push_seq_header(12'($urandom), 12'($urandom), aspect);
        2: begin
          // Start code prefix followed by some other byte.
          pkt_bytes.push_back(8'h00);
          pkt_bytes.push_back(8'h00);
          pkt_bytes.push_back(8'h01);
          push_random(1);
        end
        default: ;
      endcase
    end
    push_random($urandom_range(0, 12));
    case ($urandom_range(0, 15))
      0: pkt_bytes[$urandom_range(0, 2)] ^= 8'($urandom_range(1, 255));
      1: pkt_bytes[PosStreamId] = 8'($urandom);
      2, 3: begin
        cut = $urandom_range(1, pkt_bytes.size());
        pkt_bytes = pkt_bytes[0:cut-1];
      end
      default: ;
    endcase
  endtask

  // Receiver: draws a stall length before each result transaction, and serves the
  // one long hold-off the stimulus asks for while the sender keeps pushing bytes.
  initial begin : receiver
    int unsigned hold;
    int unsigned rx_mode;
    int unsigned served;
    out_stall = 1'b0;
    rx_mode   = 0;
    served    = 0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (served % 10 == 0) rx_mode = $urandom_range(0, 2);
      if (long_hold) begin
        hold      = LongHoldCycles;
        long_hold = 1'b0;
      end else begin
        hold = draw_gap(rx_mode);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      served++;
      @(negedge clk);
    end
  end

  // Stimulus and verdict.
  initial begin : stimulus
    logic [7:0]  bad_ids[6];
    int unsigned waited;
    bad_ids      = '{8'hBC, 8'hBE, 8'hBF, 8'hF0, 8'hFF, 8'h00};
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    long_hold    = 1'b0;
    bytes_sent   = 0;
    packets_sent = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Smallest complete packet: no PTS, empty header data and payload.
    start_header(SidPrivate1, 1'b0, 8'd0);
    send_packet($urandom_range(0, 2));

    // Lowest and highest audio ids with PTS bytes all ones, then all zeros.
    start_header(SidAudioLo, 1'b1, 8'd5);
    for (int i = PosPts0; i <= PosPts4; i++) pkt_bytes[i] = 8'hFF;
    push_random(3);
    send_packet($urandom_range(0, 2));
    start_header(SidAudioHi, 1'b1, 8'd5);
    for (int i = PosPts0; i <= PosPts4; i++) pkt_bytes[i] = 8'h00;
    send_packet($urandom_range(0, 2));

    // Sequence headers: maximum size at 16:9, zero size at 4:3, and an aspect code
    // that is neither, which leaves the aspect as it was.
    start_header(SidVideoHi, 1'b0, 8'd0);
    push_seq_header(12'hFFF, 12'hFFF, 8'h3F);
    send_packet($urandom_range(0, 2));
    start_header(SidVideoLo, 1'b1, 8'd5);
    push_seq_header(12'h000, 12'h000, 8'h20);
    push_random(2);
    send_packet($urandom_range(0, 2));
    start_header(SidVideoLo, 1'b0, 8'd2);
    push_seq_header(12'hA5C, 12'h3C7, 8'h45);
    send_packet($urandom_range(0, 2));

    // Video payload that is too short to hold a sequence start code still passes.
    start_header(SidVideoLo, 1'b0, 8'd0);
    pkt_bytes.push_back(8'h00);
    pkt_bytes.push_back(8'h00);
    send_packet($urandom_range(0, 2));

    // Broken start code in the first and in the third byte; the second packet also
    // carries a bad stream id, and the start code error has to win.
    start_header(SidPrivate1, 1'b0, 8'd0);
    pkt_bytes[0] = 8'h01;
    send_packet($urandom_range(0, 2));
    start_header(8'hFF, 1'b0, 8'd0);
    pkt_bytes[2] = 8'h00;
    send_packet($urandom_range(0, 2));

    // Stream ids just outside the accepted ranges and at the far ends of a byte.
    foreach (bad_ids[i]) begin
      start_header(bad_ids[i], 1'b1, 8'd5);
      send_packet($urandom_range(0, 2));
    end

    // Truncations: a one-byte packet, an end before the header length, a PTS cut
    // short, a payload offset past the end, and a sequence header cut short.
    pkt_bytes = {8'h00};
    send_packet($urandom_range(0, 2));
    start_header(SidVideoLo, 1'b0, 8'd0);
    pkt_bytes = pkt_bytes[0:7];
    send_packet($urandom_range(0, 2));
    start_header(SidAudioLo, 1'b1, 8'd5);
    pkt_bytes = pkt_bytes[0:12];
    send_packet($urandom_range(0, 2));
    start_header(SidPrivate1, 1'b0, 8'd10);
    pkt_bytes = pkt_bytes[0:14];
    send_packet($urandom_range(0, 2));
    start_header(SidVideoHi, 1'b0, 8'd0);
    push_seq_header(12'h123, 12'h456, 8'h30);
    pkt_bytes = pkt_bytes[0:14];
    send_packet($urandom_range(0, 2));

    // Largest header data length with the payload starting exactly at the end, then a
    // shorter header whose packet ends one byte before its payload offset.
    start_header(SidAudioHi, 1'b1, 8'd255);
    send_packet($urandom_range(0, 2));
    start_header(SidAudioHi, 1'b1, 8'd40);
    pkt_bytes = pkt_bytes[0:47];
    send_packet($urandom_range(0, 2));

    // Back pressure: the receiver holds off for a long stretch while short packets
    // keep coming, so the output and the internal queue fill up and the input stalls.
    long_hold = 1'b1;
    repeat (12) begin
      start_header(SidPrivate1, 1'b0, 8'd0);
      send_packet(0);
    end

    // Random packets until the byte budget of the run is used up and at least eight were sent.
    packets_sent = 0;
    while (bytes_sent < TotalBytes || packets_sent < RandomPackets) begin
      random_packet();
      send_packet($urandom_range(0, 2));
    end
    in_valid <= 1'b0;

    // Wait for every outstanding report, then a few more cycles to catch any extra.
    waited = 0;
    while (pending_reports != 0 && waited < DrainLimit) begin
      @(negedge clk);
      waited++;
    end
    repeat (SettleCycles) @(negedge clk);
    if (pending_reports == 0 && fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #(10 * CycleLimit);
    $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/pesh_pkg.sv
hw/rtl/pesh_front.sv
hw/rtl/pesh_queue.sv
hw/rtl/pesh_back.sv
hw/rtl/pes_header_parser.sv
tb/sv/pesh_result_checker.sv
tb/sv/pes_header_parser_tb.sv
